// ===== design/itpp_pkg.sv =====
// Shared types, constants and helpers for the isometric tile pixel placer.
// Used by itpp_walk and isometric_tile_pixel_placer; no dependencies.
package itpp_pkg;

    // Fixed field widths
    localparam int unsigned COLOR_BITS  = 16;
    localparam int unsigned PIX_BITS    = 12;   // pixel_x / pixel_y / image size
    localparam int unsigned ORIGIN_BITS = 14;   // signed tile origins, may go negative
    localparam int unsigned LINE_BITS   = 6;    // line within a tile, < 40
    localparam int unsigned XL_BITS     = 7;    // x within a tile line, < 78
    localparam int unsigned FT_BITS     = 4;    // footprint_tiles register
    localparam int unsigned CFG_IDX_BITS  = 2;
    localparam int unsigned CFG_DATA_BITS = 12;
    localparam int unsigned OUT_DATA_BITS = 40; // x, y, color: whole bytes

    // Tile geometry
    localparam logic [XL_BITS-1:0]   TILE_W_SMALL = 7'd58;
    localparam logic [XL_BITS-1:0]   TILE_W_LARGE = 7'd78;
    localparam logic [LINE_BITS-1:0] TILE_H_SMALL = 6'd30;
    localparam logic [LINE_BITS-1:0] TILE_H_LARGE = 6'd40;
    localparam logic [XL_BITS-1:0]   TILE_GAP     = 7'd2;

    // Reset values of the registers
    localparam logic                 RST_TILE_MODE = 1'b0;
    localparam logic [FT_BITS-1:0]   RST_FOOTPRINT = 4'd1;
    localparam logic [PIX_BITS-1:0]  RST_WIDTH     = 12'd58;
    localparam logic [PIX_BITS-1:0]  RST_HEIGHT    = 12'd30;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_TILE_MODE = 2'd0,
        REG_FOOTPRINT = 2'd1,
        REG_WIDTH     = 2'd2,
        REG_HEIGHT    = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic                tile_mode;
        logic [FT_BITS-1:0]  footprint_tiles;
        logic [PIX_BITS-1:0] image_width;
        logic [PIX_BITS-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [PIX_BITS-1:0] pixel_x;
        logic [PIX_BITS-1:0] pixel_y;
        logic                last;
        logic                error;
    } t_result;

    function automatic logic [XL_BITS-1:0] tile_w(input logic mode);
        return mode ? TILE_W_LARGE : TILE_W_SMALL;
    endfunction

    function automatic logic [LINE_BITS-1:0] tile_h(input logic mode);
        return mode ? TILE_H_LARGE : TILE_H_SMALL;
    endfunction

    // First x of a tile line: narrow at top and bottom, full width at mid height
    function automatic logic [XL_BITS-1:0] line_start(input logic [LINE_BITS-1:0] y,
                                                       input logic mode);
        logic [XL_BITS-1:0] h;
        logic [XL_BITS-1:0] y7;
        h  = {1'b0, tile_h(mode)};
        y7 = {1'b0, y};
        if (y7 < (h >> 1)) begin
            return h - ((y7 + 7'd1) << 1);
        end else begin
            return (y7 << 1) - h;
        end
    endfunction

endpackage

// ===== design/itpp_walk.sv =====
// Per-pixel placement logic: target coordinates, bounds check and the
// next traversal position. Depends on itpp_pkg.
module itpp_walk import itpp_pkg::*; #(
    parameter int MAX_FOOTPRINT = 8,
    parameter int COORD_BITS    = 12,
    parameter int SW            = $clog2(MAX_FOOTPRINT + 1),
    parameter int RW            = $clog2(2 * MAX_FOOTPRINT),
    parameter int TW            = (MAX_FOOTPRINT > 1) ? $clog2(MAX_FOOTPRINT) : 1
) (
    input  t_cfg                          i_cfg,
    input  logic [SW-1:0]                 i_size,
    input  logic [RW-1:0]                 i_row,
    input  logic [TW-1:0]                 i_tile,
    input  logic [LINE_BITS-1:0]          i_line,
    input  logic [XL_BITS-1:0]            i_x,
    input  logic signed [ORIGIN_BITS-1:0] i_ox,
    input  logic signed [ORIGIN_BITS-1:0] i_oy,
    input  logic                          i_done,
    output logic [RW-1:0]                 o_row,
    output logic [TW-1:0]                 o_tile,
    output logic [LINE_BITS-1:0]          o_line,
    output logic [XL_BITS-1:0]            o_x,
    output logic signed [ORIGIN_BITS-1:0] o_ox,
    output logic signed [ORIGIN_BITS-1:0] o_oy,
    output logic                          o_done,
    output t_result                       o_res
);

    localparam logic [PIX_BITS-1:0] COORD_MASK = (COORD_BITS >= PIX_BITS) ?
        {PIX_BITS{1'b1}} : PIX_BITS'((32'd1 << COORD_BITS) - 32'd1);

    logic [XL_BITS-1:0]            w;
    logic [LINE_BITS-1:0]          h;
    logic signed [ORIGIN_BITS-1:0] tx;
    logic signed [ORIGIN_BITS-1:0] ty;
    logic                          oob;
    logic [XL_BITS-1:0]            x1;
    logic [LINE_BITS-1:0]          line1;
    logic [SW-1:0]                 tile1;
    logic [RW:0]                   row_len;
    logic [RW-1:0]                 row1;
    logic [RW:0]                   rows_total;
    logic [RW-1:0]                 k;
    logic                          line_end;
    logic                          tile_end;
    logic                          row_end;
    logic                          fp_end;
    logic [LINE_BITS-1:0]          nxt_line;
    logic                          last_hit;

    // Target and bounds
    always_comb begin
        w   = tile_w(i_cfg.tile_mode);
        h   = tile_h(i_cfg.tile_mode);
        tx  = i_ox + $signed({7'd0, i_x});
        ty  = i_oy + $signed({8'd0, i_line});
        oob = tx[ORIGIN_BITS-1] || ty[ORIGIN_BITS-1] ||
              ($unsigned(tx) >= {2'b00, i_cfg.image_width}) ||
              ($unsigned(ty) >= {2'b00, i_cfg.image_height});
    end

    // Nested counter advance: x, line, tile in row, tile row
    always_comb begin
        x1         = i_x + 7'd1;
        line_end   = x1 >= (w - line_start(i_line, i_cfg.tile_mode));
        line1      = i_line + 6'd1;
        tile_end   = line1 >= h;
        tile1      = SW'(i_tile) + SW'(1);
        row_len    = ({1'b0, i_row} < (RW+1)'(i_size)) ?
                     (RW+1)'(i_row) + (RW+1)'(1) :
                     ((RW+1)'(i_size) << 1) - (RW+1)'(i_row) - (RW+1)'(1);
        row_end    = (RW+1)'(tile1) >= row_len;
        row1       = i_row + RW'(1);
        rows_total = ((RW+1)'(i_size) << 1) - (RW+1)'(1);
        fp_end     = {1'b0, row1} >= rows_total;
        k          = ((RW+1)'(row1) < (RW+1)'(i_size)) ?
                     RW'(i_size) - row1 - RW'(1) : row1 - RW'(i_size) + RW'(1);

        o_row    = i_row;
        o_tile   = i_tile;
        o_ox     = i_ox;
        o_oy     = i_oy;
        o_done   = i_done;
        nxt_line = i_line;
        o_x      = x1;
        last_hit = 1'b0;

        if (!i_done && line_end) begin
            nxt_line = line1;
            if (tile_end) begin
                nxt_line = '0;
                o_tile   = TW'(tile1);
                o_ox     = i_ox + $signed({7'd0, w + TILE_GAP});
                if (row_end) begin
                    o_tile = '0;
                    o_row  = row1;
                    o_oy   = i_oy + $signed({8'd0, h >> 1});
                    if (fp_end) begin
                        o_done   = 1'b1;
                        last_hit = 1'b1;
                    end else begin
                        o_ox = $signed(ORIGIN_BITS'(k) * ORIGIN_BITS'(h));
                    end
                end
            end
            o_x = line_start(nxt_line, i_cfg.tile_mode);
        end
        o_line = nxt_line;
    end

    // Result coordinates; a pixel past completion is flagged only
    always_comb begin
        o_res.last    = last_hit;
        o_res.error   = i_done || oob;
        o_res.pixel_x = o_res.error ? '0 : tx[PIX_BITS-1:0] & COORD_MASK;
        o_res.pixel_y = o_res.error ? '0 : ty[PIX_BITS-1:0] & COORD_MASK;
    end

endmodule

// ===== design/isometric_tile_pixel_placer.sv =====
// Top level of the isometric tile pixel placer: config registers, traversal
// state and output register. Depends on itpp_pkg and itpp_walk.
//
// Takes one RGB555 pixel beat per cycle while the output is not stalled and returns
// its position inside a diamond footprint of isometric tiles anchored at the image
// bottom. The traversal counters update in the cycle a beat is accepted, and the
// placed pixel is in the output register in the next cycle; the input side keeps
// accepting while that register is taken in the same cycle. Any register write
// restarts the footprint from its first pixel. A pixel outside the image, or one
// arriving after the last pixel of the footprint, comes out with tuser (error) set
// and zero coordinates.
module isometric_tile_pixel_placer import itpp_pkg::*; #(
    parameter int MAX_FOOTPRINT = 8,
    parameter int COORD_BITS    = 12
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // pixel input
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [COLOR_BITS-1:0]    i_s_axis_tdata,   // [15:0] color_word
    // placed pixel output
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_BITS-1:0] o_m_axis_tdata,   // [11:0] pixel_x, [23:12] pixel_y,
                                                       // [39:24] color
    output logic                     o_m_axis_tlast,   // last
    output logic                     o_m_axis_tuser    // [0] error
);

    localparam int SW = $clog2(MAX_FOOTPRINT + 1);
    localparam int RW = $clog2(2 * MAX_FOOTPRINT);
    localparam int TW = (MAX_FOOTPRINT > 1) ? $clog2(MAX_FOOTPRINT) : 1;
    localparam logic [FT_BITS:0] MAX_FP = (FT_BITS+1)'(MAX_FOOTPRINT);

    t_cfg                          r_cfg, n_cfg;
    logic                          cfg_wr;
    logic                          cfg_hit;
    logic                          in_acc;

    logic [RW-1:0]                 r_row, n_row, w_row;
    logic [TW-1:0]                 r_tile, n_tile, w_tile;
    logic [LINE_BITS-1:0]          r_line, n_line, w_line;
    logic [XL_BITS-1:0]            r_x, n_x, w_x;
    logic signed [ORIGIN_BITS-1:0] r_ox, n_ox, w_ox;
    logic signed [ORIGIN_BITS-1:0] r_oy, n_oy, w_oy;
    logic                          r_done, n_done, w_done;
    t_result                       w_res;

    logic [SW-1:0]                 size_cur;
    logic [SW-1:0]                 size_new;
    logic [LINE_BITS-1:0]          h_new;

    logic                          r_out_valid;
    t_result                       r_res;
    logic [COLOR_BITS-1:0]         r_color;

    function automatic logic [SW-1:0] eff_size(input logic [FT_BITS-1:0] ft);
        if (ft == '0) begin
            return SW'(1);
        end else if ({1'b0, ft} > MAX_FP) begin
            return SW'(MAX_FOOTPRINT);
        end else begin
            return SW'(ft);
        end
    endfunction

    // Handshakes
    assign o_cfg_ready     = 1'b1;
    assign cfg_wr          = i_cfg_valid;
    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;

    // Register write decode
    always_comb begin
        n_cfg   = r_cfg;
        cfg_hit = 1'b0;
        if (cfg_wr) begin
            cfg_hit = 1'b1;
            case (t_reg_idx'(i_cfg_index))
                REG_TILE_MODE: n_cfg.tile_mode       = i_cfg_data[0];
                REG_FOOTPRINT: n_cfg.footprint_tiles = i_cfg_data[FT_BITS-1:0];
                REG_WIDTH:     n_cfg.image_width     = i_cfg_data;
                REG_HEIGHT:    n_cfg.image_height    = i_cfg_data;
                default:       cfg_hit               = 1'b0;
            endcase
        end
    end

    assign size_cur = eff_size(r_cfg.footprint_tiles);
    assign size_new = eff_size(n_cfg.footprint_tiles);
    assign h_new    = tile_h(n_cfg.tile_mode);

    itpp_walk #(
        .MAX_FOOTPRINT (MAX_FOOTPRINT),
        .COORD_BITS    (COORD_BITS),
        .SW            (SW),
        .RW            (RW),
        .TW            (TW)
    ) u_walk (
        .i_cfg   (r_cfg),
        .i_size  (size_cur),
        .i_row   (r_row),
        .i_tile  (r_tile),
        .i_line  (r_line),
        .i_x     (r_x),
        .i_ox    (r_ox),
        .i_oy    (r_oy),
        .i_done  (r_done),
        .o_row   (w_row),
        .o_tile  (w_tile),
        .o_line  (w_line),
        .o_x     (w_x),
        .o_ox    (w_ox),
        .o_oy    (w_oy),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // Traversal next state: restart on register write, advance on accepted beat
    always_comb begin
        n_row  = r_row;
        n_tile = r_tile;
        n_line = r_line;
        n_x    = r_x;
        n_ox   = r_ox;
        n_oy   = r_oy;
        n_done = r_done;
        if (cfg_hit) begin
            n_row  = '0;
            n_tile = '0;
            n_line = '0;
            n_x    = line_start('0, n_cfg.tile_mode);
            n_ox   = $signed(ORIGIN_BITS'(size_new - SW'(1)) * ORIGIN_BITS'(h_new));
            n_oy   = $signed({2'b00, n_cfg.image_height}) -
                     $signed(ORIGIN_BITS'(size_new) * ORIGIN_BITS'(h_new));
            n_done = 1'b0;
        end else if (in_acc) begin
            n_row  = w_row;
            n_tile = w_tile;
            n_line = w_line;
            n_x    = w_x;
            n_ox   = w_ox;
            n_oy   = w_oy;
            n_done = w_done;
        end
    end

    // Config and traversal state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tile_mode       <= RST_TILE_MODE;
            r_cfg.footprint_tiles <= RST_FOOTPRINT;
            r_cfg.image_width     <= RST_WIDTH;
            r_cfg.image_height    <= RST_HEIGHT;
            r_row  <= '0;
            r_tile <= '0;
            r_line <= '0;
            r_x    <= line_start('0, RST_TILE_MODE);
            r_ox   <= $signed(ORIGIN_BITS'(eff_size(RST_FOOTPRINT) - SW'(1)) *
                              ORIGIN_BITS'(tile_h(RST_TILE_MODE)));
            r_oy   <= $signed({2'b00, RST_HEIGHT}) -
                      $signed(ORIGIN_BITS'(eff_size(RST_FOOTPRINT)) *
                              ORIGIN_BITS'(tile_h(RST_TILE_MODE)));
            r_done <= 1'b0;
        end else begin
            r_cfg  <= n_cfg;
            r_row  <= n_row;
            r_tile <= n_tile;
            r_line <= n_line;
            r_x    <= n_x;
            r_ox   <= n_ox;
            r_oy   <= n_oy;
            r_done <= n_done;
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_out_valid <= in_acc;
        end
    end

    // Output payload, loaded on each accepted beat
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res   <= w_res;
            r_color <= i_s_axis_tdata;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_color, r_res.pixel_y, r_res.pixel_x};
    assign o_m_axis_tlast  = r_res.last;
    assign o_m_axis_tuser  = r_res.error;

endmodule

// ===== test/isometric_tile_pixel_placer_tb.sv =====
// Testbench for isometric_tile_pixel_placer: drives pixel beats and register writes,
// predicts each placed pixel and checks the output stream beat by beat.
// Depends on itpp_pkg and the design files only.
`timescale 1ns / 100ps

module isometric_tile_pixel_placer_tb;
    import itpp_pkg::*;

    localparam int MAX_FOOTPRINT = 8;
    localparam int SETTLE_CYCLES = 3;     // output register plus margin
    localparam int QUIET_LIMIT   = 500;   // cycles without any pixel, output or register handshake before giving up
    localparam int MAX_REPORTS   = 10;

    // one placed pixel as it leaves the block
    typedef struct packed {
        logic [PIX_BITS-1:0]   x;
        logic [PIX_BITS-1:0]   y;
        logic [COLOR_BITS-1:0] color;
        logic                  last;
        logic                  err;
    } t_placed;

    // directed stimulus row: a register write or a pixel beat
    typedef struct {
        bit                       is_write;
        t_reg_idx                 reg_sel;
        logic [CFG_DATA_BITS-1:0] value;
        logic [COLOR_BITS-1:0]    color;
        bit                       known;
        t_placed                  want;
    } t_dir_row;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic [COLOR_BITS-1:0]     s_data    = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic [OUT_DATA_BITS-1:0]  m_data;
    logic                      m_last;
    logic                      m_user;

    t_placed     placements_due[$];
    t_dir_row    script[$];
    int unsigned fail_count   = 0;
    int unsigned quiet_cycles = 0;
    int unsigned burst_left   = 0;
    int unsigned ready_run    = 0;

    // predictor copy of the registers
    logic                 cfg_big;
    logic [FT_BITS-1:0]   cfg_tiles;
    logic [PIX_BITS-1:0]  cfg_w;
    logic [PIX_BITS-1:0]  cfg_h;

    // predictor copy of the traversal
    int unsigned walk_row, walk_tile, walk_line, walk_col;
    int          org_x, org_y;
    bit          walk_done;

    isometric_tile_pixel_placer DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user)
    );

    always #1 clk = ~clk;

    // ---------------- placement predictor ----------------

    function automatic int unsigned tile_wd();
        return cfg_big ? int'(TILE_W_LARGE) : int'(TILE_W_SMALL);
    endfunction

    function automatic int unsigned tile_ht();
        return cfg_big ? int'(TILE_H_LARGE) : int'(TILE_H_SMALL);
    endfunction

    // footprint side with out-of-range settings clamped
    function automatic int unsigned side_tiles();
        int unsigned s;
        s = cfg_tiles;
        if (s < 1) s = 1;
        if (s > MAX_FOOTPRINT) s = MAX_FOOTPRINT;
        return s;
    endfunction

    // first column of a tile line: diamond narrows toward top and bottom
    function automatic int unsigned line_first(input int unsigned ln);
        int unsigned h;
        h = tile_ht();
        if (ln < h / 2) return h - 2 * (ln + 1);
        return 2 * ln - h;
    endfunction

    function automatic int unsigned row_span(input int unsigned r, input int unsigned s);
        return (r < s) ? r + 1 : 2 * s - r - 1;
    endfunction

    function automatic int row_left(input int unsigned r, input int unsigned s);
        int unsigned k;
        k = (r < s) ? s - r - 1 : r - s + 1;
        return int'(k * tile_ht());
    endfunction

    function automatic void restart_walk();
        int unsigned s;
        s         = side_tiles();
        walk_row  = 0;
        walk_tile = 0;
        walk_line = 0;
        walk_col  = line_first(0);
        org_x     = row_left(0, s);
        org_y     = int'(cfg_h) - int'(s * tile_ht());
        walk_done = 1'b0;
    endfunction

    function automatic void apply_reg(input t_reg_idx idx, input logic [CFG_DATA_BITS-1:0] v);
        case (idx)
            REG_TILE_MODE: cfg_big   = v[0];
            REG_FOOTPRINT: cfg_tiles = v[FT_BITS-1:0];
            REG_WIDTH:     cfg_w     = v[PIX_BITS-1:0];
            REG_HEIGHT:    cfg_h     = v[PIX_BITS-1:0];
            default: ;
        endcase
        restart_walk();
    endfunction

    // target of one pixel, then advance the walk by one position
    function automatic t_placed place_pixel(input logic [COLOR_BITS-1:0] color);
        t_placed     r;
        int          tx, ty;
        bit          off_image;
        int unsigned s;
        r       = '0;
        r.color = color;
        if (walk_done) begin
            r.err = 1'b1;
            return r;
        end
        s  = side_tiles();
        tx = org_x + int'(walk_col);
        ty = org_y + int'(walk_line);
        off_image = tx < 0 || ty < 0 || tx >= int'(cfg_w) || ty >= int'(cfg_h);

        walk_col++;
        if (walk_col >= tile_wd() - line_first(walk_line)) begin
            walk_line++;
            if (walk_line >= tile_ht()) begin
                walk_line = 0;
                walk_tile++;
                org_x += int'(tile_wd()) + int'(TILE_GAP);
                if (walk_tile >= row_span(walk_row, s)) begin
                    walk_tile = 0;
                    walk_row++;
                    org_y += int'(tile_ht() / 2);
                    if (walk_row >= 2 * s - 1) begin
                        walk_done = 1'b1;
                        r.last    = 1'b1;
                    end else begin
                        org_x = row_left(walk_row, s);
                    end
                end
            end
            walk_col = line_first(walk_line);
        end

        r.err = off_image;
        if (!off_image) begin
            r.x = tx[PIX_BITS-1:0];
            r.y = ty[PIX_BITS-1:0];
        end
        return r;
    endfunction

    // ---------------- directed rows ----------------

    function automatic t_dir_row reg_row(input t_reg_idx idx, input logic [CFG_DATA_BITS-1:0] v);
        t_dir_row d;
        d          = '{reg_sel: REG_TILE_MODE, default: '0};
        d.is_write = 1'b1;
        d.reg_sel  = idx;
        d.value    = v;
        return d;
    endfunction

    function automatic t_dir_row pix_free(input logic [COLOR_BITS-1:0] c);
        t_dir_row d;
        d       = '{reg_sel: REG_TILE_MODE, default: '0};
        d.color = c;
        return d;
    endfunction

    function automatic t_dir_row pix_at(input logic [COLOR_BITS-1:0] c,
                                        input int unsigned x, input int unsigned y);
        t_dir_row d;
        d            = pix_free(c);
        d.known      = 1'b1;
        d.want.x     = x[PIX_BITS-1:0];
        d.want.y     = y[PIX_BITS-1:0];
        d.want.color = c;
        return d;
    endfunction

    // pixel whose target falls outside the image
    function automatic t_dir_row pix_off(input logic [COLOR_BITS-1:0] c);
        t_dir_row d;
        d          = pix_at(c, 0, 0);
        d.want.err = 1'b1;
        return d;
    endfunction

    // ---------------- drivers ----------------

    function automatic void log_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%s", msg);
    endfunction

    // offer one pixel beat, with bursts and gaps on the sender side
    task automatic push_pixel(input logic [COLOR_BITS-1:0] color, input t_placed want);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 250)
                                                     : $urandom_range(1, 24);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        placements_due.push_back(want);
        s_valid <= 1'b1;
        s_data  <= color;
        do @(posedge clk); while (!s_ready);
    endtask

    // holds valid high across back-to-back writes; caller lowers it
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DATA_BITS-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        apply_reg(idx, v);
    endtask

    // stop sending, wait for every placed pixel and let the pipeline settle
    task automatic drain_results();
        s_valid <= 1'b0;
        while (placements_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_extent();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 12'd1;
            2:       return 12'd4095;
            3:       return 12'($urandom_range(2, 64));
            4:       return 12'($urandom_range(200, 400));
            default: return 12'($urandom_range(1, 4095));
        endcase
    endfunction

    // ---------------- receiver stalls ----------------

    always @(posedge clk) begin
        if (ready_run != 0) begin
            ready_run <= ready_run - 1;
        end else if (m_ready) begin
            m_ready   <= 1'b0;
            ready_run <= $urandom_range(0, 7);
        end else begin
            m_ready   <= 1'b1;
            ready_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                                     : $urandom_range(0, 15);
        end
    end

    // ---------------- output check ----------------

    always @(posedge clk) begin
        t_placed got, want;
        if (rst_n && m_valid && m_ready) begin
            got.x     = m_data[PIX_BITS-1:0];
            got.y     = m_data[2*PIX_BITS-1:PIX_BITS];
            got.color = m_data[2*PIX_BITS +: COLOR_BITS];
            got.last  = m_last;
            got.err   = m_user;
            if (placements_due.size() == 0) begin
                log_mismatch($sformatf("unexpected beat: x=%0d y=%0d color=%h last=%b err=%b",
                                       got.x, got.y, got.color, got.last, got.err));
            end else begin
                want = placements_due.pop_front();
                if (got !== want)
                    log_mismatch($sformatf({"mismatch: expected x=%0d y=%0d color=%h last=%b ",
                                            "err=%b, got x=%0d y=%0d color=%h last=%b err=%b"},
                                           want.x, want.y, want.color, want.last, want.err,
                                           got.x, got.y, got.color, got.last, got.err));
            end
        end
    end

    // ---------------- watchdog ----------------

    always @(posedge clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------

    initial begin
        bit                       writing;
        t_placed                  want;
        logic [COLOR_BITS-1:0]    c;
        logic [3:0]               mask;
        int unsigned              n;

        writing = 1'b0;
        cfg_big   = RST_TILE_MODE;
        cfg_tiles = RST_FOOTPRINT;
        cfg_w     = RST_WIDTH;
        cfg_h     = RST_HEIGHT;
        restart_walk();

        // reset settings: 58x30 tile, one tile, 58x30 image
        script.push_back(pix_at(16'h0000, 28, 0));
        script.push_back(pix_at(16'hFFFF, 29, 0));
        script.push_back(pix_at(16'h8001, 26, 1));
        script.push_back(pix_free(16'h7FFE));
        // zero width: nothing lands
        script.push_back(reg_row(REG_WIDTH, 12'd0));
        script.push_back(pix_off(16'h5555));
        script.push_back(pix_off(16'hAAAA));
        // image shorter than the footprint, then zero height
        script.push_back(reg_row(REG_WIDTH, 12'd4095));
        script.push_back(reg_row(REG_HEIGHT, 12'd1));
        script.push_back(pix_off(16'h1234));
        script.push_back(reg_row(REG_HEIGHT, 12'd0));
        script.push_back(pix_off(16'hEDCB));
        script.push_back(reg_row(REG_HEIGHT, 12'd4095));
        script.push_back(pix_at(16'h0F0F, 28, 4065));
        // large tiles
        script.push_back(reg_row(REG_TILE_MODE, 12'd1));
        script.push_back(pix_at(16'hF0F0, 38, 4055));
        script.push_back(pix_free(16'h00FF));
        // footprint size 0 acts as 1
        script.push_back(reg_row(REG_FOOTPRINT, 12'hFF0));
        script.push_back(pix_at(16'hFF00, 38, 4055));
        // largest footprint, then an oversized one that clamps
        script.push_back(reg_row(REG_FOOTPRINT, 12'd8));
        script.push_back(pix_at(16'h3C3C, 318, 3775));
        script.push_back(pix_free(16'hC3C3));
        script.push_back(pix_free(16'h6996));
        script.push_back(reg_row(REG_FOOTPRINT, 12'd15));
        script.push_back(pix_at(16'h9669, 318, 3775));
        // upper data bits ignored: back to small tiles
        script.push_back(reg_row(REG_TILE_MODE, 12'hFFE));
        script.push_back(pix_at(16'h4321, 238, 3855));
        script.push_back(reg_row(REG_WIDTH, 12'd1));
        script.push_back(pix_off(16'h8421));
        script.push_back(reg_row(REG_WIDTH, 12'd58));
        script.push_back(reg_row(REG_HEIGHT, 12'd30));
        script.push_back(pix_off(16'h1248));
        script.push_back(reg_row(REG_FOOTPRINT, 12'd1));
        script.push_back(pix_at(16'h7777, 28, 0));
        script.push_back(pix_free(16'h8888));
        script.push_back(pix_free(16'hBEEF));

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (script[i]) begin
            if (script[i].is_write) begin
                if (!writing) begin
                    drain_results();
                    writing = 1'b1;
                end
                write_reg(script[i].reg_sel, script[i].value);
            end else begin
                if (writing) begin
                    cfg_valid <= 1'b0;
                    writing = 1'b0;
                end
                want = place_pixel(script[i].color);
                if (script[i].known) want = script[i].want;
                push_pixel(script[i].color, want);
            end
        end

        // random phases; one of them runs a whole one-tile footprint
        for (int ph = 0; ph < 12; ph++) begin
            drain_results();
            if (ph == 3) begin
                write_reg(REG_TILE_MODE, {11'($urandom), 1'b0});
                write_reg(REG_FOOTPRINT, {8'($urandom), 4'd1});
                // narrow image puts the final pixel outside it
                write_reg(REG_WIDTH, 12'($urandom_range(1, 29)));
                write_reg(REG_HEIGHT, 12'($urandom_range(1, 4095)));
                cfg_valid <= 1'b0;
                while (!walk_done) begin
                    c = 16'($urandom);
                    push_pixel(c, place_pixel(c));
                end
                // beats after completion
                n = $urandom_range(1, 6);
            end else begin
                mask = 4'($urandom_range(1, 15));
                if (mask[0]) write_reg(REG_TILE_MODE, 12'($urandom));
                if (mask[1]) write_reg(REG_FOOTPRINT, 12'($urandom));
                if (mask[2]) write_reg(REG_WIDTH, pick_extent());
                if (mask[3]) write_reg(REG_HEIGHT, pick_extent());
                cfg_valid <= 1'b0;
                n = $urandom_range(30, 84);
            end
            repeat (n) begin
                c = 16'($urandom);
                push_pixel(c, place_pixel(c));
            end
        end

        drain_results();
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
